FILE: sv/pbl_pkg.sv
// Package with shared types and register codes for the brake light PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pbl_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 50;
    localparam int unsigned CTRL_W      = 50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INTEG_LIMIT   = 3'd0,
        CFG_GAIN_P        = 3'd1,
        CFG_GAIN_I        = 3'd2,
        CFG_GAIN_D        = 3'd3,
        CFG_BRAKE_THRESH  = 3'd4,
        CFG_ACCEL_THRESH  = 3'd5,
        CFG_PWM_MINIMUM   = 3'd6,
        CFG_REST_LEVEL    = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic        [30:0] integ_limit;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [49:0] brake_thresh;
        logic signed [49:0] accel_thresh;
        logic        [15:0] pwm_minimum;
        logic        [15:0] rest_level;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/pbl_integrator.sv
// Error, clamped integral and derivative stage holding the PID history state.
`timescale 1ns / 1ps
`default_nettype none

module pbl_integrator
    import pbl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [16:0]      o_error,
    output logic signed [31:0]      o_integral,
    output logic signed [17:0]      o_deriv
);

    logic signed [31:0] r_integral;
    logic signed [16:0] r_last_err;
    logic               r_valid;

    logic signed [16:0] n_error;
    logic signed [32:0] sum_acc;
    logic signed [32:0] guard_pos;
    logic signed [32:0] guard_neg;
    logic signed [31:0] n_integral;
    logic signed [17:0] n_deriv;
    logic               accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_error   = 17'(i_accel_z) + 17'sd1;
        sum_acc   = 33'(r_integral) + 33'(n_error);
        guard_pos = $signed({2'b00, i_cfg.integ_limit});
        guard_neg = -guard_pos;
        if (sum_acc < guard_neg) begin
            n_integral = guard_neg[31:0];
        end else if (sum_acc > guard_pos) begin
            n_integral = guard_pos[31:0];
        end else begin
            n_integral = sum_acc[31:0];
        end
        n_deriv = 18'(n_error) - 18'(r_last_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_integral <= n_integral;
                r_last_err <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_error    <= n_error;
            o_integral <= n_integral;
            o_deriv    <= n_deriv;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pbl_mac.sv
// Gain multiplies in one stage and the control sum in the next.
`timescale 1ns / 1ps
`default_nettype none

module pbl_mac
    import pbl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [16:0] i_error,
    input  wire logic signed [31:0] i_integral,
    input  wire logic signed [17:0] i_deriv,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [CTRL_W-1:0] o_control
);

    logic signed [32:0] r_prod_p;
    logic signed [47:0] r_prod_i;
    logic signed [33:0] r_prod_d;
    logic               r_mul_valid;
    logic               r_sum_valid;
    logic               mul_ready;
    logic               sum_ready;

    assign sum_ready = !r_sum_valid || i_ready;
    assign mul_ready = !r_mul_valid || sum_ready;
    assign o_ready   = mul_ready;
    assign o_valid   = r_sum_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            if (mul_ready) begin
                r_mul_valid <= i_valid;
            end
            if (sum_ready) begin
                r_sum_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && mul_ready) begin
            r_prod_p <= 33'(i_cfg.gain_p) * 33'(i_error);
            r_prod_i <= 48'(i_cfg.gain_i) * 48'(i_integral);
            r_prod_d <= 34'(i_cfg.gain_d) * 34'(i_deriv);
        end
        if (r_mul_valid && sum_ready) begin
            o_control <= CTRL_W'(r_prod_p) + CTRL_W'(r_prod_i) + CTRL_W'(r_prod_d);
        end
    end

endmodule

`default_nettype wire

FILE: sv/pbl_intensity.sv
// Threshold compare and PWM intensity update feeding the result register.
`timescale 1ns / 1ps
`default_nettype none

module pbl_intensity
    import pbl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [CTRL_W-1:0] i_control,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [CTRL_W-1:0]     o_control,
    output logic        [15:0]           o_intensity
);

    logic [15:0] r_level;
    logic [15:0] n_level;
    logic        r_valid;
    logic        accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        if (i_control > i_cfg.brake_thresh || i_control < i_cfg.accel_thresh) begin
            n_level = i_cfg.pwm_minimum;
        end else if (r_level > i_cfg.rest_level) begin
            n_level = r_level - 16'd1;
        end else if (r_level < i_cfg.rest_level) begin
            n_level = r_level + 16'd1;
        end else begin
            n_level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_control   <= i_control;
            o_intensity <= n_level;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pid_brake_light_intensity.sv
// Top level of the brake light PID controller with configuration registers.
// A result passes the input register, integrator, multiply, sum and intensity stages in order.
// Throughput: one item per cycle; five registered stages, each holding while the next is full.
// Reset: synchronous active-low reset clears the configuration registers, the integral,
// the previous error, the PWM level and every stage valid; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module pid_brake_light_intensity
    import pbl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [15:0]      i_accel_z,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [CTRL_W-1:0]     o_control_value,
    output logic        [15:0]           o_intensity
);

    t_cfg               r_cfg;
    logic signed [15:0] r_accel_z;
    logic               r_in_valid;

    logic               integ_valid;
    logic               integ_ready;
    logic               mac_valid;
    logic               mac_ready;
    logic               pwm_valid;
    logic               pwm_ready;
    logic signed [16:0] integ_error;
    logic signed [31:0] int_integral;
    logic signed [17:0] int_deriv;
    logic signed [CTRL_W-1:0] mac_control;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_INTEG_LIMIT:  r_cfg.integ_limit  <= i_cfg_data[30:0];
                CFG_GAIN_P:       r_cfg.gain_p       <= i_cfg_data[15:0];
                CFG_GAIN_I:       r_cfg.gain_i       <= i_cfg_data[15:0];
                CFG_GAIN_D:       r_cfg.gain_d       <= i_cfg_data[15:0];
                CFG_BRAKE_THRESH: r_cfg.brake_thresh <= i_cfg_data[49:0];
                CFG_ACCEL_THRESH: r_cfg.accel_thresh <= i_cfg_data[49:0];
                CFG_PWM_MINIMUM:  r_cfg.pwm_minimum  <= i_cfg_data[15:0];
                CFG_REST_LEVEL:   r_cfg.rest_level   <= i_cfg_data[15:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_in_ready = !r_in_valid || integ_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_accel_z <= i_accel_z;
        end
    end

    pbl_integrator u_integrator (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (r_in_valid),
        .o_ready    (integ_ready),
        .i_accel_z  (r_accel_z),
        .o_valid    (integ_valid),
        .i_ready    (mac_ready),
        .o_error    (integ_error),
        .o_integral (int_integral),
        .o_deriv    (int_deriv)
    );

    pbl_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (integ_valid),
        .o_ready    (mac_ready),
        .i_error    (integ_error),
        .i_integral (int_integral),
        .i_deriv    (int_deriv),
        .o_valid    (mac_valid),
        .i_ready    (pwm_ready),
        .o_control  (mac_control)
    );

    pbl_intensity u_intensity (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (mac_valid),
        .o_ready     (pwm_ready),
        .i_control   (mac_control),
        .o_valid     (pwm_valid),
        .i_ready     (i_out_ready),
        .o_control   (o_control_value),
        .o_intensity (o_intensity)
    );

    assign o_out_valid = pwm_valid;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the brake light PID controller with random stalls and settings.
`timescale 1ns / 1ps

module testbench;
    import pbl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [CTRL_W-1:0] control;
        logic        [15:0]       intensity;
    } t_brake_result;

    // Tracks the controller state and the results it owes, oldest first.
    class t_brake_shadow;
        t_cfg               cfg;
        logic signed [31:0] integral;
        logic signed [16:0] last_err;
        logic        [15:0] level;
        t_brake_result      due_results[$];
        int                 errors;

        function new();
            cfg = '0;
            integral = '0;
            last_err = '0;
            level = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTEG_LIMIT:  cfg.integ_limit = data[30:0];
                CFG_GAIN_P:       cfg.gain_p = data[15:0];
                CFG_GAIN_I:       cfg.gain_i = data[15:0];
                CFG_GAIN_D:       cfg.gain_d = data[15:0];
                CFG_BRAKE_THRESH: cfg.brake_thresh = data[49:0];
                CFG_ACCEL_THRESH: cfg.accel_thresh = data[49:0];
                CFG_PWM_MINIMUM:  cfg.pwm_minimum = data[15:0];
                CFG_REST_LEVEL:   cfg.rest_level = data[15:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [15:0] z);
            longint        err;
            longint        guard;
            longint        acc;
            longint        slope;
            longint        ctrl;
            t_brake_result res;
            err = longint'(z) + 1;
            guard = longint'({33'd0, cfg.integ_limit});
            acc = longint'(integral) + err;
            if (acc < -guard) begin
                acc = -guard;
            end else if (acc > guard) begin
                acc = guard;
            end
            integral = acc[31:0];
            slope = err - longint'(last_err);
            last_err = err[16:0];
            ctrl = longint'($signed(cfg.gain_p)) * err
                 + longint'($signed(cfg.gain_i)) * acc
                 + longint'($signed(cfg.gain_d)) * slope;
            if (ctrl > longint'($signed(cfg.brake_thresh))
                    || ctrl < longint'($signed(cfg.accel_thresh))) begin
                level = cfg.pwm_minimum;
            end else if (level > cfg.rest_level) begin
                level = level - 16'd1;
            end else if (level < cfg.rest_level) begin
                level = level + 16'd1;
            end
            res.control = ctrl[CTRL_W-1:0];
            res.intensity = level;
            due_results.push_back(res);
        endfunction

        function void match_output(logic signed [CTRL_W-1:0] ctrl, logic [15:0] inten);
            t_brake_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: control_value %0d intensity %0d", ctrl, inten);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (ctrl !== want.control) begin
                $error("control_value: expected %0d, actual %0d", want.control, ctrl);
                errors++;
            end
            if (inten !== want.intensity) begin
                $error("intensity: expected %0d, actual %0d", want.intensity, inten);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [15:0]         i_accel_z = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [CTRL_W-1:0]   o_control_value;
    logic        [15:0]         o_intensity;

    t_brake_shadow      shadow;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    logic signed [15:0] last_sample = '0;
    int                 cycle_count = 0;

    pid_brake_light_intensity dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_accel_z       (i_accel_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_control_value (o_control_value),
        .o_intensity     (o_intensity)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                shadow.take_sample(i_accel_z);
            end
            if (o_out_valid && i_out_ready) begin
                shadow.match_output(o_control_value, o_intensity);
            end
        end
    end

    // The receiver stalls at random; on request it holds off long enough to fill the pipeline.
    always begin
        int held;
        @(negedge i_clk);
        if (hold_req) begin
            i_out_ready <= 1'b0;
            for (held = 0; held < 80; held++) begin
                @(negedge i_clk);
            end
            hold_req = 1'b0;
        end
        i_out_ready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic load_settings(input logic [30:0] guard, input logic signed [15:0] gp,
                                 input logic signed [15:0] gi, input logic signed [15:0] gd,
                                 input logic signed [49:0] brake,
                                 input logic signed [49:0] accel,
                                 input logic [15:0] pmin, input logic [15:0] pidle);
        logic [CFG_DATA_W-1:0] value [8];
        logic [63:0]           junk;
        logic [63:0]           word;
        t_cfg_index            idx;
        int                    w;
        value[0] = guard;
        value[1] = gp;
        value[2] = gi;
        value[3] = gd;
        value[4] = brake;
        value[5] = accel;
        value[6] = pmin;
        value[7] = pidle;
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_index'(i);
            case (idx)
                CFG_INTEG_LIMIT: w = 31;
                CFG_BRAKE_THRESH, CFG_ACCEL_THRESH: w = 50;
                default: w = 16;
            endcase
            // Random bits above the register width must be dropped by the block.
            junk = {$urandom, $urandom};
            word = (junk << w) | ({14'd0, value[i]} & ((64'd1 << w) - 64'd1));
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= word[CFG_DATA_W-1:0];
            shadow.write_reg(idx, word[CFG_DATA_W-1:0]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] z);
        while (!calm && $urandom_range(99) < 14) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_accel_z <= z;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            last_sample = 16'($urandom);
        end else if (r < 70) begin
            last_sample = 16'(int'($urandom_range(8)) - 4);
        end else if (r < 85) begin
            case ($urandom_range(3))
                0: last_sample = 16'sh8000;
                1: last_sample = 16'sh7FFF;
                2: last_sample = -16'sd1;
                default: last_sample = 16'sd0;
            endcase
        end
        return last_sample;
    endfunction

    function automatic logic signed [15:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            return 16'sd0;
        end else if (r < 30) begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end else if (r < 60) begin
            return 16'(int'($urandom_range(1024)) - 512);
        end
        return 16'($urandom);
    endfunction

    function automatic logic signed [49:0] pick_threshold(input bit positive);
        logic [63:0] r;
        longint      v;
        int          k;
        if ($urandom_range(9) == 0) begin
            return positive ? 50'sh1_FFFF_FFFF_FFFF : 50'sh2_0000_0000_0000;
        end
        k = $urandom_range(46);
        r = {$urandom, $urandom};
        v = longint'(r & ((64'd1 << k) - 64'd1));
        if ($urandom_range(4) == 0) begin
            positive = !positive;
        end
        return positive ? v[49:0] : 50'(-v);
    endfunction

    initial begin
        logic [30:0] guard;
        logic [15:0] pmin;
        logic [15:0] pidle;
        shadow = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings straight out of reset: control stays zero and the intensity holds at idle.
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        finish_phase();

        // Extreme gains, widest guard, thresholds that can never trip: drift toward idle.
        load_settings(31'h7FFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                      50'sh1_FFFF_FFFF_FFFF, 50'sh2_0000_0000_0000, 16'hFFFF, 16'hFFFF);
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        finish_phase();

        // Both thresholds met at once on a zero control.
        load_settings(31'd100, 16'sd0, 16'sd0, 16'sd0, -50'sd1000, 50'sd1000, 16'd1234, 16'd0);
        send_sample(16'sd7);
        send_sample(-16'sd7);
        send_sample(16'sd100);
        send_sample(16'sh7FFF);
        finish_phase();

        // Zero guard pins the integral; opposite extreme gains and zero thresholds.
        load_settings(31'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 50'sd0, 50'sd0, 16'd0, 16'd3);
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd5);
        send_sample(-16'sd5);
        send_sample(-16'sd1);
        finish_phase();

        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(3))
                0: guard = 31'd0;
                1: guard = 31'h7FFF_FFFF;
                2: guard = 31'($urandom_range(5000));
                default: guard = 31'($urandom);
            endcase
            pmin = 16'($urandom);
            if ($urandom_range(1)) begin
                pidle = pmin + 16'($urandom_range(40)) - 16'd20;
            end else begin
                pidle = 16'($urandom);
            end
            load_settings(guard, pick_gain(), pick_gain(), pick_gain(),
                          pick_threshold(1'b1), pick_threshold(1'b0), pmin, pidle);
            calm = (p == 3);
            if (p == 6) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < 110; k++) begin
                send_sample(pick_sample());
            end
            finish_phase();
            calm = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
